// ===== rtl/chained_hash_key_value_table_macros.svh =====
// Assertion macros for the hash table checker.
`ifndef CHAINED_HASH_KEY_VALUE_TABLE_MACROS_SVH
`define CHAINED_HASH_KEY_VALUE_TABLE_MACROS_SVH
// Assert an implication at every clock edge outside reset.
`define CHKV_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error(msg);
// Assert an implication whose right-hand side must hold in the next cycle.
`define CHKV_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error(msg);
`endif

// ===== rtl/chkv_pkg.sv =====
// ----------------------------------------------------------------------------
// chkv_pkg
// Shared codes for the chained hash key/value table.
// ----------------------------------------------------------------------------
package chkv_pkg;
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int HASH_SHIFT = 16;
endpackage

// ===== rtl/chkv_node_mem.sv =====
// ----------------------------------------------------------------------------
// chkv_node_mem
// Node pool memory: key, value and next link per node, registered read.
// ----------------------------------------------------------------------------
module chkv_node_mem #(
	parameter int NODE_COUNT = 64,
	parameter int LW = 7
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(NODE_COUNT)-1:0] waddr,
	input  logic                        wr_kv,
	input  logic [chkv_pkg::KEY_W-1:0]  wkey,
	input  logic [chkv_pkg::VAL_W-1:0]  wval,
	input  logic [LW-1:0]               wnext,
	input  logic [$clog2(NODE_COUNT)-1:0] raddr,
	output logic [chkv_pkg::KEY_W-1:0]  rkey,
	output logic [chkv_pkg::VAL_W-1:0]  rval,
	output logic [LW-1:0]               rnext
);
	logic [chkv_pkg::KEY_W-1:0] key_mem [NODE_COUNT];
	logic [chkv_pkg::VAL_W-1:0] val_mem [NODE_COUNT];
	logic [LW-1:0]              next_mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			next_mem[waddr] <= wnext;
			if (wr_kv) begin
				key_mem[waddr] <= wkey;
				val_mem[waddr] <= wval;
			end
		end
		rkey  <= key_mem[raddr];
		rval  <= val_mem[raddr];
		rnext <= next_mem[raddr];
	end
endmodule

// ===== rtl/chained_hash_key_value_table.sv =====
// ----------------------------------------------------------------------------
// chained_hash_key_value_table
// Separate-chaining hash table of 32-bit keys and values with a node pool.
// ----------------------------------------------------------------------------
// Channel | Dir | Contents
// s_axis  | in  | tuser=action, tdata=lookup_key, entry_value
// m_axis  | out | tdata=status, found_value
// One request at a time: each request reads its bucket head; insert then links
// a new node in front of the head, while search and delete walk the chain,
// reading each node and comparing its key, and a delete hit unlinks the match.
// A full pool on insert or an unused action goes straight to the result.
// After reset a clearing pass writes bucket heads and the free list, one
// entry a cycle; no request is taken until it ends.
// A result waits in the output register; the next request is taken while it
// waits but cannot finish until the output is taken.
module chained_hash_key_value_table #(
	parameter int BUCKET_COUNT = 64,
	parameter int NODE_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata, // lookup_key[31:0], entry_value[63:32]
	input  logic [1:0]  s_axis_tuser, // action[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata  // status[1:0], found_value[33:2], zero pad
);
	localparam int BW = $clog2(BUCKET_COUNT);
	localparam int NW = $clog2(NODE_COUNT);
	localparam int LW = $clog2(NODE_COUNT + 1);
	localparam int CW = (BW > NW ? BW : NW) + 1;
	localparam int CLR_N = BUCKET_COUNT > NODE_COUNT ? BUCKET_COUNT : NODE_COUNT;
	localparam int SW = LW + 1;
	localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_HEAD = 4'd2,
		S_HWAIT = 4'd3, S_NODE = 4'd4, S_CMP = 4'd5, S_FIX = 4'd6,
		S_OUT = 4'd7, S_INSW = 4'd8;

	logic [3:0] state_q;
	logic [CW-1:0] clr_q;
	logic [1:0] act_q;
	logic [chkv_pkg::KEY_W-1:0] key_q;
	logic [chkv_pkg::VAL_W-1:0] val_q;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] free_q, cur_q, prev_q, head_q;
	logic [SW-1:0] steps_q;
	logic [LW-1:0] count_q;
	logic [1:0] res_st_q;
	logic [chkv_pkg::VAL_W-1:0] res_val_q;
	logic out_v_q;
	logic [1:0] out_st_q;
	logic [chkv_pkg::VAL_W-1:0] out_val_q;

	// bucket head memory
	logic [LW-1:0] head_mem [BUCKET_COUNT];
	logic [LW-1:0] head_rd;
	logic hwe;
	logic [BW-1:0] hwa;
	logic [LW-1:0] hwd;

	always_ff @(posedge clk) begin
		if (hwe) head_mem[hwa] <= hwd;
		head_rd <= head_mem[bkt_q];
	end

	// node pool
	logic nwe, nkv;
	logic [NW-1:0] nwa, nra;
	logic [LW-1:0] nwn;
	logic [chkv_pkg::KEY_W-1:0] rkey;
	logic [chkv_pkg::VAL_W-1:0] rval;
	logic [LW-1:0] rnext;

	chkv_node_mem #(.NODE_COUNT(NODE_COUNT), .LW(LW)) u_nodes (
		.clk(clk), .we(nwe), .waddr(nwa), .wr_kv(nkv), .wkey(key_q), .wval(val_q),
		.wnext(nwn), .raddr(nra), .rkey(rkey), .rval(rval), .rnext(rnext)
	);

	logic [chkv_pkg::KEY_W-1:0] hkey;
	assign hkey = s_axis_tdata[31:0] ^ (s_axis_tdata[31:0] >> chkv_pkg::HASH_SHIFT);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;
	// hold the waiting result apart from the working registers of the next request
	assign m_axis_tdata = {6'd0, out_val_q, out_st_q};

	// memory write and read selection
	always_comb begin
		hwe = 1'b0; hwa = bkt_q; hwd = NIL;
		nwe = 1'b0; nkv = 1'b0; nwa = cur_q[NW-1:0]; nwn = NIL;
		nra = cur_q[NW-1:0];
		case (state_q)
			S_CLR: begin
				hwa = clr_q[BW-1:0];
				hwe = clr_q < CW'(BUCKET_COUNT);
				nwa = clr_q[NW-1:0];
				nwe = clr_q < CW'(NODE_COUNT);
				nwn = LW'(clr_q) + LW'(1);
			end
			S_INSW: begin
				// link new node in front of the old head, make it the head
				nwe = 1'b1; nkv = 1'b1; nwa = free_q[NW-1:0]; nwn = head_q;
				hwe = 1'b1; hwd = free_q;
			end
			S_FIX: begin
				// unlink the match, then return it to the free list
				if (prev_q == NIL) begin
					hwe = 1'b1; hwd = rnext;
				end else begin
					nwe = 1'b1; nwa = prev_q[NW-1:0]; nwn = rnext;
				end
			end
			S_OUT: begin
				if (act_q == chkv_pkg::ACT_DELETE && res_st_q == chkv_pkg::ST_OK) begin
					nwe = 1'b1; nwa = cur_q[NW-1:0]; nwn = free_q;
				end
			end
			S_HWAIT: nra = free_q[NW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			out_v_q <= 1'b0;
			free_q <= '0;
			count_q <= '0;
		end else begin
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CLR_N - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (s_axis_tvalid) begin
					act_q <= s_axis_tuser;
					key_q <= s_axis_tdata[31:0];
					val_q <= s_axis_tdata[63:32];
					bkt_q <= BW'(hkey % BUCKET_COUNT);
					state_q <= S_HEAD;
				end
				S_HEAD: state_q <= S_HWAIT;
				S_HWAIT: begin
					// head_rd valid now; free node's next is being read
					head_q <= head_rd;
					cur_q <= head_rd;
					prev_q <= NIL;
					steps_q <= '0;
					res_val_q <= '0;
					res_st_q <= chkv_pkg::ST_NOT_FOUND;
					if (act_q == chkv_pkg::ACT_INSERT) begin
						if (free_q == NIL) begin
							res_st_q <= chkv_pkg::ST_FULL;
							state_q <= S_OUT;
						end else state_q <= S_INSW;
					end else if (act_q == chkv_pkg::ACT_DELETE ||
						act_q == chkv_pkg::ACT_SEARCH) begin
						state_q <= S_NODE;
					end else state_q <= S_OUT;
				end
				S_INSW: begin
					free_q <= rnext;
					if (count_q < NIL) count_q <= count_q + LW'(1);
					res_st_q <= chkv_pkg::ST_OK;
					state_q <= S_OUT;
				end
				S_NODE: begin
					// issue node read, or stop on end of chain or after NODE_COUNT nodes
					if (cur_q >= NIL || steps_q == SW'(NODE_COUNT)) state_q <= S_OUT;
					else state_q <= S_CMP;
				end
				S_CMP: begin
					if (rkey == key_q) begin
						res_st_q <= chkv_pkg::ST_OK;
						if (act_q == chkv_pkg::ACT_SEARCH) begin
							res_val_q <= rval;
							state_q <= S_OUT;
						end else state_q <= S_FIX;
					end else begin
						prev_q <= cur_q;
						cur_q <= rnext;
						steps_q <= steps_q + SW'(1);
						state_q <= S_NODE;
					end
				end
				S_FIX: state_q <= S_OUT;
				S_OUT: if (!out_v_q) begin
					out_v_q <= 1'b1;
					out_st_q <= res_st_q;
					out_val_q <= res_val_q;
					if (act_q == chkv_pkg::ACT_DELETE && res_st_q == chkv_pkg::ST_OK) begin
						free_q <= cur_q;
						if (count_q != '0) count_q <= count_q - LW'(1);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/chkv_checker.sv =====
// ----------------------------------------------------------------------------
// chkv_checker
// Port-level checks for the chained hash key/value table.
// ----------------------------------------------------------------------------
`include "chained_hash_key_value_table_macros.svh"
module chkv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	`CHKV_ASSERT_IMP(a_status_code, clk, arst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "bad status")
	`CHKV_ASSERT_IMP(a_value_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[1:0] != 2'd0, m_axis_tdata[33:2] == 32'd0, "value not zero")
	`CHKV_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken")
	`CHKV_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output dropped")
endmodule

bind chained_hash_key_value_table chkv_checker u_chkv_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
